// ----- hdl/lls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types and fixed widths of the lane line selector.
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int DIM_W      = 13;  // image_width / image_height registers
  localparam int SLOPE_W    = 16;  // Q8.8 slope limits
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_W      = 8;   // reported segment index
  localparam int CROSS_W    = 25;  // reported bottom-row crossing
  localparam int CROSS_MAX  = 2**(CROSS_W-1) - 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MIN_SLOPE    = 2'd2,
    CFG_MAX_SLOPE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                      found;
    logic [IDX_W-1:0]          left_index;
    logic [IDX_W-1:0]          right_index;
    logic signed [CROSS_W-1:0] left_cross;
    logic signed [CROSS_W-1:0] right_cross;
    logic                      overflowed;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/lls_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lls_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lls_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   part;
  logic [DEN_W+1:0] diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // shift next dividend bit into the partial remainder, trial subtract
  assign part    = {rem_r, quo_r[NUM_W-1]};
  assign diff    = {1'b0, part} - {2'b00, den_r};
  assign ge      = ~diff[DEN_W+1];
  assign rem_nxt = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- hdl/lane_line_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lane_line_selector
// Picks the left and right lane lines of a frame from a stream of segments.
// ----------------------------------------------------------------------------
// One segment item is taken at a time. A horizontal or vertical segment is
// done in S_MIN, a segment outside the slope band or beyond MAX_LINES in
// S_MIN, S_MAX and S_CHK, and a kept segment passes on through S_HMUL,
// S_SUM, S_DIV and S_UPD. In S_DIV a restoring divider forms the bottom-row
// crossing from a NUM_W-bit dividend, NUM_W = COORD_BITS + max(13,
// COORD_BITS) + 3 (28 at the default 12-bit coordinates), one quotient bit
// per cycle; the slope test and crossing numerator run through one shared
// max(17, max(13, COORD_BITS) + 1) x (COORD_BITS+1) multiplier. An item
// with tlast set loads the frame result in S_OUT once the output register is
// free; that register holds it while the next segment is already being taken.
// ----------------------------------------------------------------------------
module lane_line_selector #(
  parameter int MAX_LINES  = 256,
  parameter int COORD_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // segment items
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // x_start, y_start, x_end, y_end (COORD_BITS each), zero pad
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                              in_tlast,   // last_segment
  // result items
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // found, left_index(8), right_index(8), left_cross(25), right_cross(25),
  // overflowed, zero pad
  output logic [71:0]                            out_tdata,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [lls_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [lls_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = lls_pkg::DIM_W;
  localparam int HY_W  = ((CW > DW) ? CW : DW) + 1;
  localparam int MA_W  = (lls_pkg::SLOPE_W + 1 > HY_W) ? lls_pkg::SLOPE_W + 1 : HY_W;
  localparam int MB_W  = CW + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int NUM_W = CW + 1 + HY_W + 1;
  localparam int CR_W  = (NUM_W + 1 > lls_pkg::CROSS_W + 1) ? NUM_W + 1
                                                             : lls_pkg::CROSS_W + 1;
  localparam int KC_W  = $clog2(MAX_LINES + 1);
  localparam int XW    = lls_pkg::CROSS_W;
  localparam int IW    = lls_pkg::IDX_W;
  localparam logic signed [CR_W-1:0] CR_HI = CR_W'(lls_pkg::CROSS_MAX);
  localparam logic signed [CR_W-1:0] CR_LO = CR_W'(-lls_pkg::CROSS_MAX - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MIN  = 9'b000000010,
    S_MAX  = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_HMUL = 9'b000010000,
    S_SUM  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DW-1:0]                  img_w_r;
  logic [DW-1:0]                  img_h_r;
  logic [lls_pkg::SLOPE_W-1:0]    min_slope_r;
  logic [lls_pkg::SLOPE_W-1:0]    max_slope_r;

  // current segment
  logic [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic          last_r;

  // frame state
  logic [KC_W-1:0]        kept_count_r;
  logic                   left_valid_r, right_valid_r, overflow_seen_r;
  logic signed [XW-1:0]   left_best_r, right_best_r;
  logic [IW-1:0]          left_idx_r, right_idx_r;

  // datapath
  logic signed [P_W-1:0]   prod_r;
  logic signed [NUM_W-1:0] acc_r;
  logic                    flat_r;
  logic                    neg_r;
  lls_pkg::result_t        res_r;
  logic                    out_valid_r;

  logic signed [CW:0]      dx, dy;
  logic [CW-1:0]           adx, ady;
  logic signed [HY_W-1:0]  hy;
  logic signed [P_W-1:0]   ady_sh;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   mul_p;
  logic signed [NUM_W-1:0] term;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_quo;
  logic signed [CR_W-1:0]  q_ext, cross_w;
  logic signed [XW-1:0]    cross_sat;
  logic signed [XW-1:0]    half_w;
  logic                    steep;
  logic                    in_acc, out_load, frame_clr;
  logic                    left_upd, right_upd;
  state_t                  fin_state;

  assign dx  = $signed({1'b0, x2_r}) - $signed({1'b0, x1_r});
  assign dy  = $signed({1'b0, y2_r}) - $signed({1'b0, y1_r});
  assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign hy  = $signed(HY_W'(img_h_r)) - $signed(HY_W'(y1_r));
  // |dy| * 256 for the cross-multiplied slope test
  assign ady_sh = $signed({{(P_W-CW-8){1'b0}}, ady, 8'd0});
  assign steep  = prod_r < ady_sh;

  // shared multiplier operand select
  always_comb begin
    mul_a = $signed(MA_W'(min_slope_r));
    mul_b = $signed({1'b0, adx});
    unique case (state_r)
      S_MAX:   mul_a = $signed(MA_W'(max_slope_r));
      S_CHK: begin
        mul_a = MA_W'(dy);
        mul_b = $signed({1'b0, x1_r});
      end
      S_HMUL: begin
        mul_a = MA_W'(hy);
        mul_b = dx;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // crossing numerator: x1*dy + dx*(H - y1)
  assign term    = NUM_W'($signed(prod_r[NUM_W-2:0]));
  assign num     = acc_r + term;
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  lls_div #(
    .NUM_W (NUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (ady),
    .done     (div_done),
    .quotient (div_quo)
  );

  // signed, truncated toward zero, then saturated
  assign q_ext   = $signed({{(CR_W-NUM_W){1'b0}}, div_quo});
  assign cross_w = neg_r ? -q_ext : q_ext;
  always_comb begin
    if (cross_w > CR_HI) begin
      cross_sat = XW'(CR_HI);
    end else if (cross_w < CR_LO) begin
      cross_sat = XW'(CR_LO);
    end else begin
      cross_sat = XW'(cross_w);
    end
  end

  assign half_w    = $signed({{(XW-DW+1){1'b0}}, img_w_r[DW-1:1]});
  assign left_upd  = (cross_sat <= half_w) && (!left_valid_r || cross_sat > left_best_r);
  assign right_upd = (cross_sat >= half_w) && (!right_valid_r || cross_sat < right_best_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign frame_clr = out_load;
  assign fin_state = last_r ? S_OUT : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MIN;
      S_MIN: begin
        if (dx == '0 || dy == '0) state_nxt = fin_state;
        else                      state_nxt = S_MAX;
      end
      S_MAX: state_nxt = S_CHK;
      S_CHK: begin
        if (flat_r || steep || kept_count_r >= KC_W'(MAX_LINES)) state_nxt = fin_state;
        else                                                    state_nxt = S_HMUL;
      end
      S_HMUL: state_nxt = S_SUM;
      S_SUM: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: if (div_done) state_nxt = S_UPD;
      S_UPD: state_nxt = fin_state;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (out_load)                  out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= DW'(640);
      img_h_r     <= DW'(480);
      min_slope_r <= lls_pkg::SLOPE_W'(128);
      max_slope_r <= lls_pkg::SLOPE_W'(1024);
    end else if (cfg_we) begin
      unique case (lls_pkg::cfg_idx_t'(cfg_addr))
        lls_pkg::CFG_IMAGE_WIDTH:  img_w_r     <= cfg_wdata[DW-1:0];
        lls_pkg::CFG_IMAGE_HEIGHT: img_h_r     <= cfg_wdata[DW-1:0];
        lls_pkg::CFG_MIN_SLOPE:    min_slope_r <= cfg_wdata;
        lls_pkg::CFG_MAX_SLOPE:    max_slope_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n || frame_clr) begin
      kept_count_r    <= '0;
      left_valid_r    <= 1'b0;
      right_valid_r   <= 1'b0;
      left_best_r     <= '0;
      right_best_r    <= '0;
      left_idx_r      <= '0;
      right_idx_r     <= '0;
      overflow_seen_r <= 1'b0;
    end else begin
      if (state_r == S_CHK && !flat_r && !steep && kept_count_r >= KC_W'(MAX_LINES)) begin
        overflow_seen_r <= 1'b1;
      end
      if (state_r == S_UPD) begin
        kept_count_r <= kept_count_r + 1'b1;
        if (left_upd) begin
          left_valid_r <= 1'b1;
          left_best_r  <= cross_sat;
          left_idx_r   <= IW'(kept_count_r);
        end
        if (right_upd) begin
          right_valid_r <= 1'b1;
          right_best_r  <= cross_sat;
          right_idx_r   <= IW'(kept_count_r);
        end
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r   <= in_tdata[CW-1:0];
      y1_r   <= in_tdata[2*CW-1:CW];
      x2_r   <= in_tdata[3*CW-1:2*CW];
      y2_r   <= in_tdata[4*CW-1:3*CW];
      last_r <= in_tlast;
    end
    prod_r <= mul_p;
    if (state_r == S_MAX)  flat_r <= ady_sh < prod_r;
    if (state_r == S_HMUL) acc_r  <= term;
    if (state_r == S_SUM)  neg_r  <= num[NUM_W-1] ^ dy[CW];
    if (out_load) begin
      res_r.found       <= left_valid_r && right_valid_r;
      res_r.left_index  <= (left_valid_r && right_valid_r) ? left_idx_r   : '0;
      res_r.right_index <= (left_valid_r && right_valid_r) ? right_idx_r  : '0;
      res_r.left_cross  <= (left_valid_r && right_valid_r) ? left_best_r  : '0;
      res_r.right_cross <= (left_valid_r && right_valid_r) ? right_best_r : '0;
      res_r.overflowed  <= overflow_seen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       res_r.overflowed,
                       res_r.right_cross,
                       res_r.left_cross,
                       res_r.right_index,
                       res_r.left_index,
                       res_r.found};

endmodule
`default_nettype wire

// ----- tb/tb_lane_line_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lane_line_selector
// Self-checking bench for the lane line selector.
// ----------------------------------------------------------------------------
// Segment items go in on the input stream. A tracker class predicts the
// lane pick of every frame as items are accepted. Each frame result from the
// output stream is compared field by field against the oldest prediction.
// The run steps through several register settings, extremes included. Both
// stream sides idle at random. One phase holds the output off long enough to
// back the block up into its input.
// ----------------------------------------------------------------------------
module tb_lane_line_selector;

  localparam int MAX_SEGS    = 256;
  localparam int COORD_W     = 12;
  localparam int IN_W        = ((4*COORD_W+7)/8)*8;
  localparam int SETTLE_CYC  = 64;
  localparam int HOLD_CYC    = 1500;   // long output hold-off
  localparam int STALL_LIMIT = 10000;  // cycles with no item moving
  localparam int PHASE_ITEMS = 155;

  typedef struct {
    bit [COORD_W-1:0] xs;
    bit [COORD_W-1:0] ys;
    bit [COORD_W-1:0] xe;
    bit [COORD_W-1:0] ye;
    bit               is_last;
  } seg_t;

  // Tracks the frame state and holds the lane picks still due.
  class lane_tracker;
    bit [lls_pkg::DIM_W-1:0]   width_px;
    bit [lls_pkg::DIM_W-1:0]   height_px;
    bit [lls_pkg::SLOPE_W-1:0] slope_lo;
    bit [lls_pkg::SLOPE_W-1:0] slope_hi;
    int                        kept;
    bit                        have_left;
    bit                        have_right;
    longint                    left_x;
    longint                    right_x;
    int                        left_idx;
    int                        right_idx;
    bit                        dropped;
    lls_pkg::result_t          picks_due[$];
    int                        errors;

    function new();
      width_px  = lls_pkg::DIM_W'(640);
      height_px = lls_pkg::DIM_W'(480);
      slope_lo  = lls_pkg::SLOPE_W'(128);
      slope_hi  = lls_pkg::SLOPE_W'(1024);
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      kept       = 0;
      have_left  = 0;
      have_right = 0;
      left_x     = 0;
      right_x    = 0;
      left_idx   = 0;
      right_idx  = 0;
      dropped    = 0;
    endfunction

    function void set_reg(lls_pkg::cfg_idx_t idx, bit [lls_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        lls_pkg::CFG_IMAGE_WIDTH:  width_px  = v[lls_pkg::DIM_W-1:0];
        lls_pkg::CFG_IMAGE_HEIGHT: height_px = v[lls_pkg::DIM_W-1:0];
        lls_pkg::CFG_MIN_SLOPE:    slope_lo  = v;
        lls_pkg::CFG_MAX_SLOPE:    slope_hi  = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return picks_due.size();
    endfunction

    function void note_segment(seg_t s);
      longint           dx, dy, ady, adx, num, den, cr, hw;
      lls_pkg::result_t r;
      dx = longint'(s.xe) - longint'(s.xs);
      dy = longint'(s.ye) - longint'(s.ys);
      if (dx != 0 && dy != 0) begin
        ady = (dy < 0 ? -dy : dy) * 256;
        adx = dx < 0 ? -dx : dx;
        if (!(ady < longint'(slope_lo) * adx) && !(longint'(slope_hi) * adx < ady)) begin
          if (kept >= MAX_SEGS) begin
            dropped = 1;
          end else begin
            num = longint'(s.xs) * dy + dx * (longint'(height_px) - longint'(s.ys));
            den = dy;
            if (den < 0) begin
              den = -den;
              num = -num;
            end
            cr = num / den;  // truncates toward zero
            if (cr > lls_pkg::CROSS_MAX) cr = lls_pkg::CROSS_MAX;
            if (cr < -longint'(lls_pkg::CROSS_MAX) - 1) cr = -longint'(lls_pkg::CROSS_MAX) - 1;
            hw = longint'(width_px >> 1);
            // a crossing right at half width competes on both sides
            if (cr <= hw && (!have_left || cr > left_x)) begin
              have_left = 1;
              left_x    = cr;
              left_idx  = kept;
            end
            if (cr >= hw && (!have_right || cr < right_x)) begin
              have_right = 1;
              right_x    = cr;
              right_idx  = kept;
            end
            kept++;
          end
        end
      end
      if (s.is_last) begin
        r = '0;
        r.found = have_left && have_right;
        if (r.found) begin
          r.left_index  = left_idx[lls_pkg::IDX_W-1:0];
          r.right_index = right_idx[lls_pkg::IDX_W-1:0];
          r.left_cross  = left_x[lls_pkg::CROSS_W-1:0];
          r.right_cross = right_x[lls_pkg::CROSS_W-1:0];
        end
        r.overflowed = dropped;
        picks_due.insert(picks_due.size(), r);
        clear_frame();
      end
    endfunction

    function void cmp(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t  %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [71:0] d);
      lls_pkg::result_t want;
      if (picks_due.size() == 0) begin
        errors++;
        $display("%0t  result with no frame pending: expected none, got %h", $time, d);
        return;
      end
      want = picks_due.pop_front();
      cmp("found", want.found, d[0]);
      cmp("left_index", want.left_index, d[8:1]);
      cmp("right_index", want.right_index, d[16:9]);
      cmp("left_cross", want.left_cross, $signed(d[41:17]));
      cmp("right_cross", want.right_cross, $signed(d[66:42]));
      cmp("overflowed", want.overflowed, d[67]);
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;   // x_start, y_start, x_end, y_end
  logic            in_tlast;   // last_segment
  logic            out_tvalid;
  logic            out_tready;
  // found, left_index, right_index, left_cross, right_cross, overflowed
  logic [71:0]     out_tdata;
  logic            cfg_we;
  logic [lls_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lls_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lane_tracker tracker = new();

  bit quiet;        // no idling on either side
  bit hold_req;
  bit hold_done;
  int cur_w, cur_h, cur_lo, cur_hi;
  int stall_cycles;
  int phase_items;
  seg_t prev_seg;

  lane_line_selector #(
    .MAX_LINES (MAX_SEGS),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random ready, one long hold-off on request
  initial begin
    int held;
    held = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        tracker.check_result(out_tdata);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        held++;
        if (held >= HOLD_CYC) hold_done = 1;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_seg(seg_t s);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.ye, s.xe, s.ys, s.xs};
    in_tlast  <= s.is_last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    tracker.note_segment(s);
    phase_items++;
  endtask

  task automatic send_xy(int x1, int y1, int x2, int y2, bit lst);
    seg_t s;
    s.xs = COORD_W'(x1);
    s.ys = COORD_W'(y1);
    s.xe = COORD_W'(x2);
    s.ye = COORD_W'(y2);
    s.is_last = lst;
    send_seg(s);
  endtask

  // drain all results, then give the block time to finish dropped items
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_config(int w, int h, int lo, int hi);
    lls_pkg::cfg_idx_t idx [4];
    int                val [4];
    idx = '{lls_pkg::CFG_IMAGE_WIDTH, lls_pkg::CFG_IMAGE_HEIGHT,
            lls_pkg::CFG_MIN_SLOPE, lls_pkg::CFG_MAX_SLOPE};
    val = '{w, h, lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= lls_pkg::CFG_DATA_W'(val[i]);
      @(posedge clk);
      tracker.set_reg(idx[i], lls_pkg::CFG_DATA_W'(val[i]));
    end
    cfg_we <= 1'b0;
    cur_w  = w;
    cur_h  = h;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Mostly segments whose slope falls in the current band, some noise.
  function automatic seg_t make_seg(bit keep_only);
    seg_t s;
    int   kind, slope, adx, ady, x0, y0;
    bit   neg_x, neg_y;
    s.xs = COORD_W'($urandom_range(0, 4095));
    s.ys = COORD_W'($urandom_range(0, 4095));
    s.xe = COORD_W'($urandom_range(0, 4095));
    s.ye = COORD_W'($urandom_range(0, 4095));
    s.is_last = 1'b0;
    kind = keep_only ? 99 : $urandom_range(0, 99);
    if (kind < 8) begin
      s.ye = s.ys;
      return s;
    end
    if (kind < 14) begin
      s.xe = s.xs;
      return s;
    end
    if (kind < 24) return s;
    if (cur_lo <= cur_hi && cur_hi != 0)
      slope = $urandom_range(cur_lo > 0 ? cur_lo : 1, cur_hi);
    else
      slope = $urandom_range(32, 2048);
    adx = $urandom_range(1, 600);
    ady = (adx * slope + 128) / 256;
    if (ady > 4095) begin
      adx = (4095 * 256) / slope;
      if (adx < 1) adx = 1;
      ady = (adx * slope + 128) / 256;
      if (ady > 4095) ady = 4095;
    end
    if (ady == 0) ady = 1;
    neg_x = 1'($urandom_range(0, 1));
    neg_y = 1'($urandom_range(0, 1));
    if (kind < 30 && cur_h <= 4095 && (cur_h >= ady || cur_h + ady <= 4095)) begin
      // starts right on the bottom row at half width
      s.xs = COORD_W'(cur_w / 2);
      s.ys = COORD_W'(cur_h);
      s.xe = COORD_W'((cur_w / 2 + adx <= 4095) ? cur_w / 2 + adx : cur_w / 2 - adx);
      s.ye = COORD_W'((cur_h >= ady) ? cur_h - ady : cur_h + ady);
      return s;
    end
    x0 = $urandom_range(0, 4095 - adx);
    y0 = $urandom_range(0, 4095 - ady);
    s.xs = COORD_W'(neg_x ? x0 + adx : x0);
    s.xe = COORD_W'(neg_x ? x0 : x0 + adx);
    s.ys = COORD_W'(neg_y ? y0 + ady : y0);
    s.ye = COORD_W'(neg_y ? y0 : y0 + ady);
    return s;
  endfunction

  task automatic send_frame(int n, bit keep_only);
    seg_t s;
    for (int i = 0; i < n; i++) begin
      // repeat an earlier segment now and then to force ties
      if (i > 0 && $urandom_range(0, 99) < 8)
        s = prev_seg;
      else
        s = make_seg(keep_only);
      s.is_last = (i == n - 1);
      send_seg(s);
      prev_seg = s;
    end
  endtask

  initial begin
    int n;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= lls_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata  <= '0;
    quiet        = 0;
    hold_req     = 0;
    phase_items  = 0;
    cur_w = 640; cur_h = 480; cur_lo = 128; cur_hi = 1024;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values in force, written once anyway
    load_config(640, 480, 128, 1024);
    send_xy(10, 100, 300, 100, 0);     // horizontal
    send_xy(50, 10, 50, 400, 0);       // vertical
    send_xy(0, 0, 1000, 10, 0);        // too flat
    send_xy(0, 0, 1, 4000, 0);         // too steep
    send_xy(100, 200, 200, 400, 0);    // left, crosses at 240
    send_xy(500, 200, 400, 400, 0);    // right, crosses at 360
    send_xy(320, 480, 420, 280, 0);    // exactly half width, both sides
    send_xy(320, 480, 420, 280, 1);    // tie, earlier one stays
    send_xy(100, 200, 200, 400, 1);    // one side only: not found
    send_xy(0, 0, 0, 0, 1);            // nothing kept
    send_xy(0, 0, 2, 1, 0);            // slope right at the lower limit
    send_xy(10, 10, 11, 14, 0);        // slope right at the upper limit
    send_xy(10, 10, 11, 15, 0);        // just above it
    send_xy(4095, 4095, 0, 0, 0);
    send_xy(4095, 0, 4093, 1, 1);
    settle();

    // widest registers, crossings saturate both ways
    load_config(8191, 8191, 0, 65535);
    send_xy(0, 0, 4095, 1, 0);
    send_xy(4095, 0, 0, 1, 1);
    send_xy(0, 4095, 4095, 0, 1);
    settle();

    load_config(0, 0, 0, 65535);
    send_xy(100, 200, 200, 400, 0);
    send_xy(500, 200, 400, 400, 1);
    settle();

    // min above max rejects everything
    load_config(1, 1, 65535, 0);
    send_xy(100, 200, 200, 400, 1);
    settle();

    // more kept segments than the block tracks
    load_config(640, 480, 128, 1024);
    send_frame(300, 1);
    send_frame(262, 1);
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 0)
        load_config(640, 480, 128, 1024);
      else if (p == 5)
        load_config(4096, 4096, 0, 8191);
      else begin
        n = $urandom_range(0, 1024);
        load_config($urandom_range(1, 4096), $urandom_range(1, 4096), n,
                    n + $urandom_range(0, 4096));
      end
      quiet = (p == 3);
      if (p == 1) hold_req = 1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (p == 1 && !hold_done)
          n = $urandom_range(1, 2);
        else if ($urandom_range(0, 99) < 5)
          n = $urandom_range(20, 40);
        else
          n = $urandom_range(1, 8);
        send_frame(n, 0);
      end
      settle();
    end
    quiet = 0;

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
